/* hdl/bdil_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_pkg: shared types and constants for the cross dilation unit
// Sizes, field widths and the records that travel between the line buffer,
// the result queue and the top level.
// ----------------------------------------------------------------------------
package bdil_pkg;

    localparam int DEF_MAX_SIZE = 1024;
    localparam int MIN_SIZE     = 3;
    localparam int RESET_SIZE   = 1024;
    localparam int CFG_W        = 11;
    localparam int OUT_W        = 10;

    // Neighborhood pixels read from the line stores for the current column
    typedef struct packed {
        logic above;
        logic right;
        logic up2;
    } window_t;

    // One accepted pixel that produces results; row/col already cut to OUT_W
    typedef struct packed {
        logic [OUT_W-1:0] row;
        logic [OUT_W-1:0] col;
        logic             val;
        logic             cur;
        logic             last_row;
        logic             last_pix;
    } entry_t;

endpackage

/* hdl/binary_cross_dilation_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_cross_dilation_unit: streaming 3x3 cross dilation of a binary image
// Raster-order pixels in, dilated pixels of the previous row out; the last row also sends its own pixels.
// ----------------------------------------------------------------------------
// The unit takes one pixel per clock while in_stall is low and answers
// each pixel of row r with the dilated pixel of row r-1 at the same column
// (row 0 gives nothing). During the last row each pixel gives two
// transactions, the pixel above and then the pixel itself, so there the
// output port limits the input rate. Input stall rises only when the
// two-entry result queue is full. The line stores are read ahead at the
// column the next pixel will have, so the pixel is combined with its
// neighbors in the cycle it is accepted and lands in the result queue at
// that edge. The newer row lives in even and odd banks so a column and its
// right neighbor come out of one read. No clearing pass follows reset: a
// fill count marks the written part of the stores, and entries past it read
// as zero. Writing cfg_wdata (clamped to 3..MAX_SIZE) restarts the image at
// row 0, column 0 and keeps the stored rows; write it only while idle.
// ----------------------------------------------------------------------------
module binary_cross_dilation_unit #(
    parameter int MAX_SIZE = bdil_pkg::DEF_MAX_SIZE
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bdil_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        pixel_in,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bdil_pkg::OUT_W-1:0]  out_row,
    output logic [bdil_pkg::OUT_W-1:0]  out_col,
    output logic                        pixel_out,
    output logic                        run_end,
    output logic                        image_end
);
    import bdil_pkg::*;

    localparam int AW      = $clog2(MAX_SIZE);
    localparam int FW      = $clog2(MAX_SIZE + 1);
    localparam int RST_DIM = (RESET_SIZE > MAX_SIZE) ? MAX_SIZE : RESET_SIZE;

    logic [FW-1:0] size_reg;
    logic [FW-1:0] size_next;
    logic [FW-1:0] size_m1;
    logic [AW-1:0] row_reg;
    logic [AW-1:0] row_next;
    logic [AW-1:0] col_reg;
    logic [AW-1:0] col_next;
    logic          left_reg;
    logic          left_next;

    logic          accept;
    logic          q_full;
    logic          last_col;
    logic          last_row;
    logic          border;
    logic          right_px;
    logic          dil_val;
    window_t       win;
    entry_t        entry;

    assign accept  = in_valid & ~in_stall;
    assign in_stall = q_full;
    assign size_m1 = size_reg - FW'(1);

    // Position tests for the pixel on the input port
    assign last_col = (FW'(col_reg) == size_m1);
    assign last_row = (FW'(row_reg) == size_m1);
    assign border   = (row_reg == AW'(1)) || (col_reg == '0) || last_col;
    assign right_px = win.right & ((FW'(col_reg) + FW'(1)) < size_reg);
    assign dil_val  = border ? win.above
                             : (win.up2 | left_reg | win.above | right_px | pixel_in);

    assign entry.row      = OUT_W'(row_reg);
    assign entry.col      = OUT_W'(col_reg);
    assign entry.val      = dil_val;
    assign entry.cur      = pixel_in;
    assign entry.last_row = last_row;
    assign entry.last_pix = last_row & last_col;

    // Advance the raster position; a size write restarts the image
    always_comb
    begin
        size_next = size_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        left_next = left_reg;
        if (cfg_we)
        begin
            if (int'(cfg_wdata) < MIN_SIZE)
            begin
                size_next = FW'(MIN_SIZE);
            end
            else if (int'(cfg_wdata) > MAX_SIZE)
            begin
                size_next = FW'(MAX_SIZE);
            end
            else
            begin
                size_next = FW'(cfg_wdata);
            end
            row_next  = '0;
            col_next  = '0;
            left_next = 1'b0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_next  = '0;
                left_next = 1'b0;
                row_next  = last_row ? '0 : row_reg + AW'(1);
            end
            else
            begin
                col_next  = col_reg + AW'(1);
                left_next = win.above;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= FW'(RST_DIM);
            row_reg  <= '0;
            col_reg  <= '0;
            left_reg <= 1'b0;
        end
        else
        begin
            size_reg <= size_next;
            row_reg  <= row_next;
            col_reg  <= col_next;
            left_reg <= left_next;
        end
    end

    // Line stores: prefetch at the next column, shift rows on accept
    bdil_linebuf #(
        .MAX_SIZE (MAX_SIZE)
    ) u_linebuf (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_col   (col_next),
        .wr_en    (accept),
        .wr_col   (col_reg),
        .wr_cur   (pixel_in),
        .wr_above (win.above),
        .win      (win)
    );

    // Drop row-0 pixels; everything else queues one record
    bdil_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && (row_reg != '0)),
        .push_data (entry),
        .full      (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .pixel_out (pixel_out),
        .run_end   (run_end),
        .image_end (image_end)
    );

endmodule

/* hdl/bdil_linebuf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_linebuf: two line stores with prefetched reads
// The newer row is split in even/odd banks so a column and its right
// neighbor are read together; a fill count stands in for clearing.
// ----------------------------------------------------------------------------
module bdil_linebuf #(
    parameter int  MAX_SIZE = bdil_pkg::DEF_MAX_SIZE,
    localparam int AW       = $clog2(MAX_SIZE),
    localparam int FW       = $clog2(MAX_SIZE + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [AW-1:0]    rd_col,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_col,
    input  logic             wr_cur,
    input  logic             wr_above,
    output bdil_pkg::window_t win
);
    import bdil_pkg::*;

    localparam int BW         = AW - 1;
    localparam int BANK_DEPTH = 1 << BW;

    logic newer_even [0:BANK_DEPTH-1];
    logic newer_odd  [0:BANK_DEPTH-1];
    logic older      [0:MAX_SIZE-1];

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [FW-1:0] rd_ext;
    logic [FW-1:0] rd_ext_p1;
    logic [FW-1:0] wr_ext_p1;
    logic [BW-1:0] even_addr;
    logic [BW-1:0] odd_addr;

    logic even_q;
    logic odd_q;
    logic older_q;
    logic par_reg;
    logic above_ok_reg;
    logic right_ok_reg;

    assign rd_ext    = FW'(rd_col);
    assign rd_ext_p1 = rd_ext + FW'(1);
    assign wr_ext_p1 = FW'(wr_col) + FW'(1);
    assign even_addr = rd_ext_p1[BW:1];
    assign odd_addr  = rd_col[AW-1:1];

    // Entries below the fill count hold written data; the rest read as zero
    always_comb
    begin
        fill_next = fill_reg;
        if (wr_en && (wr_ext_p1 > fill_reg))
        begin
            fill_next = wr_ext_p1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg     <= '0;
            above_ok_reg <= 1'b0;
            right_ok_reg <= 1'b0;
            par_reg      <= 1'b0;
        end
        else
        begin
            fill_reg     <= fill_next;
            above_ok_reg <= (rd_ext < fill_reg);
            right_ok_reg <= (rd_ext_p1 < fill_reg);
            par_reg      <= rd_col[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !wr_col[0])
        begin
            newer_even[wr_col[AW-1:1]] <= wr_cur;
        end
        if (wr_en && wr_col[0])
        begin
            newer_odd[wr_col[AW-1:1]] <= wr_cur;
        end
        if (wr_en)
        begin
            older[wr_col] <= wr_above;
        end
        even_q  <= newer_even[even_addr];
        odd_q   <= newer_odd[odd_addr];
        older_q <= older[rd_col];
    end

    assign win.above = above_ok_reg & (par_reg ? odd_q : even_q);
    assign win.right = right_ok_reg & (par_reg ? even_q : odd_q);
    assign win.up2   = above_ok_reg & older_q;

endmodule

/* hdl/bdil_outq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_outq: two-entry result queue
// Holds one record per pixel and sends one or two results from it.
// ----------------------------------------------------------------------------
module bdil_outq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  bdil_pkg::entry_t            push_data,
    output logic                        full,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bdil_pkg::OUT_W-1:0]  out_row,
    output logic [bdil_pkg::OUT_W-1:0]  out_col,
    output logic                        pixel_out,
    output logic                        run_end,
    output logic                        image_end
);
    import bdil_pkg::*;

    entry_t     slot_reg [0:1];
    entry_t     head;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       phase_reg;
    logic       take;
    logic       pop;

    assign head      = slot_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign take      = out_valid & ~out_stall;
    assign pop       = take & (phase_reg | ~head.last_row);

    // Phase 0 sends the row above; phase 1 sends the last-row pixel itself
    assign out_row   = phase_reg ? head.row : head.row - OUT_W'(1);
    assign out_col   = head.col;
    assign pixel_out = phase_reg ? head.cur : head.val;
    assign run_end   = phase_reg | ~head.last_row;
    assign image_end = phase_reg & head.last_pix;

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                phase_reg  <= 1'b0;
            end
            else if (take)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/bdil_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdil_checker: port-level checks for the cross dilation unit
// Watches the handshakes and result fields over time.
// ----------------------------------------------------------------------------
module bdil_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bdil_pkg::OUT_W-1:0]  out_row,
    input logic [bdil_pkg::OUT_W-1:0]  out_col,
    input logic                        pixel_out,
    input logic                        run_end,
    input logic                        image_end
);
    import bdil_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_col)
            && $stable(pixel_out) && $stable(run_end) && $stable(image_end))
        else $error("result changed while stalled");

    // The image end is always the last result of its pixel
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_end |-> run_end)
        else $error("image end without run end");

    // The second result of a last-row pixel follows at once, same column, next row
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_end |=> out_valid
            && out_col == $past(out_col) && out_row == $past(out_row) + OUT_W'(1))
        else $error("broken last-row result pair");

    // Input is never stalled while no result is pending
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty output");

endmodule

bind binary_cross_dilation_unit bdil_checker u_bdil_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_row   (out_row),
    .out_col   (out_col),
    .pixel_out (pixel_out),
    .run_end   (run_end),
    .image_end (image_end)
);
